@@ src/tpwg_pkg.sv @@
// tagged pixel write gate: shared types, screen constants and controller codes
// no dependencies; used by tpwg_ctrl, tpwg_dp and tagged_pixel_write_gate
package tpwg_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int TAG_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

    // coordinate magnitude and linear index widths
    localparam int COORD_W = 11;
    localparam int IDX_W   = 2 * COORD_W;
    localparam int PIX_W   = 17;

    localparam logic [1:0] TAG_CLEAR  = 2'd0;
    localparam logic [1:0] TAG_LOCKED = 2'd1;
    localparam logic [1:0] TAG_FORCED = 2'd2;

    localparam logic MODE_DRAW  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [15:0]        colour_in;
        logic               draw_wanted;
        logic [1:0]         new_tag;
    } item_t;

    typedef struct packed {
        logic        fb_write;
        logic [16:0] pixel_index;
        logic [15:0] colour_out;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic read;
        logic decide;
        logic clr_start;
        logic clr_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } status_t;

endpackage

@@ src/tagged_pixel_write_gate.sv @@
// tagged pixel write gate: top level joining controller and datapath
// depends on tpwg_pkg, tpwg_ctrl and tpwg_dp
//
// usage:
//   an item is presented on item and taken at a rising edge where start is
//   high and busy is low. every item gives one result on result, shown for
//   exactly one cycle with result_valid high; the receiver cannot stall it.
//   a draw item runs through the steps bounds check and index multiply, tag
//   read, decide and tag write, and result register, in that order; busy is
//   high after the transfer until the decide step ends, so no new item is taken before then.
//   the controller runs these steps one after another for each draw.
//   a clear item sweeps the tag memory one entry per cycle, with busy high
//   until all width times height entries are cleared, and the all-zero result appears
//   the cycle after the sweep ends.
//   after reset the same sweep runs once with busy high throughout,
//   and gives no result.
//   whenever fb_write is low, pixel_index and colour_out are zero.
module tagged_pixel_write_gate (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tpwg_pkg::item_t   item,
    output tpwg_pkg::result_t result,
    output logic              result_valid
);

    tpwg_pkg::cmd_t    cmd;
    tpwg_pkg::status_t status;

    tpwg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tpwg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ src/tpwg_ctrl.sv @@
// tagged pixel write gate: controller state machine
// depends on tpwg_pkg; drives the datapath through tpwg_pkg::cmd_t
module tpwg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  tpwg_pkg::status_t status,
    output tpwg_pkg::cmd_t    cmd,
    output logic             busy
);

    tpwg_pkg::state_t state_reg;
    tpwg_pkg::state_t state_next;
    logic             report_reg;
    logic             report_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tpwg_pkg::ST_CLEAR;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        case (state_reg)
            tpwg_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next  = tpwg_pkg::ST_IDLE;
                    report_next = 1'b0;
                end
            end
            tpwg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == tpwg_pkg::MODE_CLEAR)
                    begin
                        state_next  = tpwg_pkg::ST_CLEAR;
                        report_next = 1'b1;
                    end
                    else
                    begin
                        state_next = tpwg_pkg::ST_CALC;
                    end
                end
            end
            tpwg_pkg::ST_CALC:   state_next = tpwg_pkg::ST_READ;
            tpwg_pkg::ST_READ:   state_next = tpwg_pkg::ST_DECIDE;
            tpwg_pkg::ST_DECIDE: state_next = tpwg_pkg::ST_IDLE;
            default:             state_next = tpwg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            tpwg_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                cmd.emit     = status.clr_last & report_reg;
            end
            tpwg_pkg::ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.load      = start;
                cmd.clr_start = start & (mode == tpwg_pkg::MODE_CLEAR);
            end
            tpwg_pkg::ST_CALC:   cmd.calc = 1'b1;
            tpwg_pkg::ST_READ:   cmd.read = 1'b1;
            tpwg_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cmd.emit   = 1'b1;
            end
            default:             busy = 1'b1;
        endcase
    end

endmodule

@@ src/tpwg_dp.sv @@
// tagged pixel write gate: datapath with item register, index unit and tag memory
// depends on tpwg_pkg; controlled by tpwg_ctrl through tpwg_pkg::cmd_t
module tpwg_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  tpwg_pkg::item_t   item,
    input  tpwg_pkg::cmd_t    cmd,
    output tpwg_pkg::status_t status,
    output tpwg_pkg::result_t result,
    output logic              result_valid
);

    localparam logic [tpwg_pkg::COORD_W-1:0] SCR_W = tpwg_pkg::COORD_W'(tpwg_pkg::SCREEN_WIDTH);
    localparam logic [tpwg_pkg::COORD_W-1:0] SCR_H =
        tpwg_pkg::COORD_W'(tpwg_pkg::SCREEN_HEIGHT);
    localparam logic [tpwg_pkg::TAG_AW-1:0] CLR_LAST =
        tpwg_pkg::TAG_AW'(tpwg_pkg::TAG_DEPTH - 1);

    logic [1:0] tag_mem [tpwg_pkg::TAG_DEPTH];

    tpwg_pkg::item_t            item_reg;
    logic [tpwg_pkg::IDX_W-1:0] idx_reg;
    logic [tpwg_pkg::IDX_W-1:0] idx_next;
    logic                       onscr_reg;
    logic                       onscr_next;
    logic [1:0]                 tag_reg;
    logic [tpwg_pkg::TAG_AW-1:0] clr_cnt_reg;
    logic [tpwg_pkg::TAG_AW-1:0] mem_addr;
    logic                       wr_en;
    logic [tpwg_pkg::TAG_AW-1:0] wr_addr;
    logic [1:0]                 wr_data;
    logic                       allowed;
    tpwg_pkg::result_t          result_reg;
    tpwg_pkg::result_t          result_next;
    logic                       valid_reg;

    // bounds check and linear index
    always_comb
    begin
        onscr_next = !item_reg.pos_x[11] && !item_reg.pos_y[11]
                     && (item_reg.pos_x[tpwg_pkg::COORD_W-1:0] < SCR_W)
                     && (item_reg.pos_y[tpwg_pkg::COORD_W-1:0] < SCR_H);
        idx_next = tpwg_pkg::IDX_W'(item_reg.pos_y[tpwg_pkg::COORD_W-1:0]) *
                   tpwg_pkg::IDX_W'(SCR_W)
                   + tpwg_pkg::IDX_W'(item_reg.pos_x[tpwg_pkg::COORD_W-1:0]);
    end

    assign mem_addr = onscr_reg ? idx_reg[tpwg_pkg::TAG_AW-1:0] : '0;
    assign allowed  = onscr_reg && (tag_reg != tpwg_pkg::TAG_LOCKED);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = mem_addr;
        wr_data = item_reg.new_tag;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = tpwg_pkg::TAG_CLEAR;
        end
        else if (cmd.decide && allowed)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        result_next = '0;
        if (cmd.decide && allowed &&
            (item_reg.draw_wanted || (tag_reg == tpwg_pkg::TAG_FORCED)))
        begin
            result_next.fb_write    = 1'b1;
            result_next.pixel_index = idx_reg[tpwg_pkg::PIX_W-1:0];
            result_next.colour_out  = item_reg.colour_in;
        end
    end

    assign status.clr_last = (clr_cnt_reg == CLR_LAST);

    // tag memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr] <= wr_data;
        end
        if (cmd.read)
        begin
            tag_reg <= tag_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.calc)
        begin
            idx_reg   <= idx_next;
            onscr_reg <= onscr_next;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.clr_start)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step && !status.clr_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule
